// ----- rtl/rbpa_pkg.sv -----
// Shared types and codes for the region bitmap page allocator.
package rbpa_pkg;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NEXT  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SKIPPED   = 4'd1,
    ST_FULL      = 4'd2,
    ST_OVERLAP   = 4'd3,
    ST_NOMEM     = 4'd4,
    ST_PROTECTED = 4'd5,
    ST_BADFREE   = 4'd6,
    ST_NONE      = 4'd7,
    ST_CLAMPED   = 4'd8
  } status_t;

  localparam logic [3:0] ET_AVAIL    = 4'd1;
  localparam logic [3:0] ET_RESERVED = 4'd2;

  localparam logic [1:0] REG_KERNEL_END     = 2'd0;
  localparam logic [1:0] REG_PROTECTED_END  = 2'd1;
  localparam logic [1:0] REG_LOW_MEMORY_END = 2'd2;

  localparam int          PADDR_W        = 5;
  localparam logic [63:0] LOW_MEM_RESET  = 64'h0000_0000_0010_0000;

  typedef struct packed {
    logic clear;
    logic capture;
    logic prep;
    logic load_b;
    logic scan;
    logic insert;
    logic alloc_chk;
    logic free_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  early;
    logic  clear_last;
    logic  scan_end;
    logic  hit;
    logic  alloc_found;
    logic  alloc_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/rbpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rbpa_ctrl.sv -----
// Controller state machine for the page allocator.
module rbpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rbpa_pkg::sts_t sts,
  output rbpa_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_PREP   = 11'b000_0000_0100,
    S_LOAD_B = 11'b000_0000_1000,
    S_SCAN   = 11'b000_0001_0000,
    S_INSERT = 11'b000_0010_0000,
    S_FRD    = 11'b000_0100_0000,
    S_FWR    = 11'b000_1000_0000,
    S_ARD    = 11'b001_0000_0000,
    S_ACHK   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.early) state_next = S_DONE;
        else if (sts.func == rbpa_pkg::FN_LOAD) state_next = S_LOAD_B;
        else state_next = S_SCAN;
      end
      S_LOAD_B: begin
        cmd.load_b = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = (sts.func == rbpa_pkg::FN_LOAD) ? S_INSERT : S_DONE;
        end else if (sts.hit) begin
          unique case (sts.func)
            rbpa_pkg::FN_ALLOC: state_next = S_ARD;
            rbpa_pkg::FN_FREE:  state_next = S_FRD;
            default:            state_next = S_DONE;
          endcase
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_FRD: state_next = S_FWR;
      S_FWR: begin
        cmd.free_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_ARD: state_next = S_ACHK;
      S_ACHK: begin
        cmd.alloc_chk = 1'b1;
        if (sts.alloc_found) state_next = S_DONE;
        else if (sts.alloc_last) state_next = S_SCAN;
        else state_next = S_ARD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_PREP)
    else $error("accepted word did not start processing");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready && !cmd.scan)
    else $error("work during clearing pass");

endmodule

// ----- rtl/rbpa_datapath.sv -----
// Datapath: config registers, region table, bitmap RAM, result registers.
module rbpa_datapath #(
  parameter int MAX_REGIONS  = 4,
  parameter int REGION_PAGES = 4096,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rbpa_pkg::cmd_t                   cmd,
  output rbpa_pkg::sts_t                   sts,
  input  logic [1:0]                       func,
  input  logic [63:0]                      address,
  input  logic [63:0]                      length,
  input  logic [3:0]                       entry_type,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       status,
  output logic [63:0]                      page_address,
  output logic                             page_type,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rbpa_pkg::PADDR_W-1:0]     paddr,
  input  logic [63:0]                      pwdata,
  output logic [63:0]                      prdata
);

  localparam int PW    = 64 - PAGE_SHIFT;
  localparam int PW1   = PW + 1;
  localparam int NCW   = $clog2(REGION_PAGES + 1);
  localparam int IW    = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;
  localparam int CW    = $clog2(MAX_REGIONS + 1);
  localparam int WORDS = (REGION_PAGES + 63) / 64;
  localparam int DEPTH = MAX_REGIONS * WORDS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam logic [64:0] PAGE_BYTES = 65'd1 << PAGE_SHIFT;

  // config
  logic [63:0] kernel_end, protected_end, low_memory_end;

  // captured word
  rbpa_pkg::func_t func_q;
  logic [63:0]     addr_q, len_q;
  logic [3:0]      type_q;

  // working registers
  logic [PW-1:0]  base_q;
  logic [63:0]    wq;
  logic           len_zero_q;
  logic [NCW-1:0] cnt_q;
  logic [CW-1:0]  i_q, pos_q;
  logic           pos_found;
  logic [AW-1:0]  ram_addr_q, clr_q;
  logic [5:0]     bit_q;
  logic [NCW-1:0] ofs_q;

  // region table
  logic [PW-1:0]  rb [MAX_REGIONS];
  logic [NCW-1:0] rc [MAX_REGIONS];
  logic           ra [MAX_REGIONS];
  logic [IW-1:0]  rs [MAX_REGIONS];
  logic [CW-1:0]  region_count;

  rbpa_pkg::status_t res_status;
  logic [63:0]       res_page;
  logic              res_type;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata, ram_rdata;

  rbpa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_addr_q),
    .rdata (ram_rdata)
  );

  // APB
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end     <= '0;
      protected_end  <= '0;
      low_memory_end <= rbpa_pkg::LOW_MEM_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx == rbpa_pkg::REG_KERNEL_END) kernel_end <= pwdata;
      if (cfg_idx == rbpa_pkg::REG_PROTECTED_END) protected_end <= pwdata;
      if (cfg_idx == rbpa_pkg::REG_LOW_MEMORY_END) low_memory_end <= pwdata;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rbpa_pkg::REG_KERNEL_END:     prdata = kernel_end;
      rbpa_pkg::REG_PROTECTED_END:  prdata = protected_end;
      rbpa_pkg::REG_LOW_MEMORY_END: prdata = low_memory_end;
      default:                      prdata = '0;
    endcase
  end

  // prep stage
  logic              avail, skip, full, prot, last_c, nx_c, early;
  logic [63:0]       start, last_s, last_v;
  logic [63:0]       nx;
  rbpa_pkg::status_t early_status;

  always_comb begin
    avail  = (type_q == rbpa_pkg::ET_AVAIL);
    skip   = !((avail && addr_q >= low_memory_end) || type_q == rbpa_pkg::ET_RESERVED);
    full   = region_count >= CW'(MAX_REGIONS);
    start  = (avail && kernel_end > addr_q) ? kernel_end : addr_q;
    {last_c, last_s} = {1'b0, addr_q} + {1'b0, len_q - 64'd1};
    last_v = last_c ? '1 : last_s;
    {nx_c, nx} = {1'b0, addr_q} + PAGE_BYTES;
    prot   = addr_q <= protected_end;
    unique case (func_q)
      rbpa_pkg::FN_LOAD: begin
        early        = skip || full;
        early_status = skip ? rbpa_pkg::ST_SKIPPED : rbpa_pkg::ST_FULL;
      end
      rbpa_pkg::FN_NEXT: begin
        early        = nx_c;
        early_status = rbpa_pkg::ST_NONE;
      end
      rbpa_pkg::FN_FREE: begin
        early        = prot;
        early_status = rbpa_pkg::ST_PROTECTED;
      end
      default: begin
        early        = 1'b0;
        early_status = rbpa_pkg::ST_OK;
      end
    endcase
  end

  // load size stage
  logic [PW:0] stop_p, raw;
  always_comb begin
    stop_p = {1'b0, wq[63:PAGE_SHIFT]} + PW1'(1);
    raw    = (len_zero_q || stop_p <= {1'b0, base_q}) ? '0 : stop_p - {1'b0, base_q};
  end

  // region scan
  logic [IW-1:0]  idx;
  logic [PW-1:0]  eb;
  logic [NCW-1:0] ec;
  logic [PW:0]    es, stop_new;
  logic           scan_end, hit;
  logic [AW-1:0]  slot_base;
  logic [PW-1:0]  foff_w;
  logic [NCW-1:0] foff;
  logic [63:0]    ebytes;

  always_comb begin
    idx       = i_q[IW-1:0];
    eb        = rb[idx];
    ec        = rc[idx];
    es        = {1'b0, eb} + PW1'(ec);
    stop_new  = {1'b0, base_q} + PW1'(cnt_q);
    scan_end  = i_q >= region_count;
    slot_base = AW'(rs[idx] * WORDS);
    foff_w    = base_q - eb;
    foff      = foff_w[NCW-1:0];
    ebytes    = {eb, {PAGE_SHIFT{1'b0}}};
    unique case (func_q)
      rbpa_pkg::FN_LOAD:  hit = !(({1'b0, base_q} >= es) || (stop_new <= {1'b0, eb}));
      rbpa_pkg::FN_ALLOC: hit = ra[idx] && ec != '0;
      rbpa_pkg::FN_FREE:  hit = ra[idx] && base_q >= eb && {1'b0, base_q} < es;
      default:            hit = {1'b0, wq[63:PAGE_SHIFT]} < es;
    endcase
  end

  // bitmap word search
  logic [NCW-1:0] rem;
  logic           a_last, a_found;
  logic [63:0]    vmask, freeb;
  logic [5:0]     first;

  always_comb begin
    rem    = ec - ofs_q;
    a_last = rem <= NCW'(64);
    vmask  = (rem >= NCW'(64)) ? '1 : ((64'd1 << rem[5:0]) - 64'd1);
    freeb  = ~ram_rdata & vmask;
    a_found = |freeb;
    first  = '0;
    for (int j = 63; j >= 0; j--) begin
      if (freeb[j]) first = 6'(j);
    end
  end

  always_comb begin
    ram_we    = cmd.clear || (cmd.alloc_chk && a_found) || cmd.free_wr;
    ram_waddr = cmd.clear ? clr_q : ram_addr_q;
    if (cmd.clear) ram_wdata = '0;
    else if (cmd.free_wr) ram_wdata = ram_rdata & ~(64'd1 << bit_q);
    else ram_wdata = ram_rdata | (64'd1 << first);
  end

  // control state
  logic [CW-1:0] ins_pos;
  assign ins_pos = pos_found ? pos_q : region_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q        <= '0;
      region_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear) clr_q <= clr_q + AW'(1);
      if (cmd.insert) region_count <= region_count + CW'(1);
      if (cmd.finish && sts.out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= rbpa_pkg::func_t'(func);
      addr_q <= address;
      len_q  <= length;
      type_q <= entry_type;
    end
    if (cmd.prep) begin
      base_q     <= (func_q == rbpa_pkg::FN_FREE) ? addr_q[63:PAGE_SHIFT]
                                                  : start[63:PAGE_SHIFT];
      wq         <= (func_q == rbpa_pkg::FN_NEXT) ? nx : last_v;
      len_zero_q <= (len_q == '0);
      res_status <= early ? early_status : rbpa_pkg::ST_OK;
      res_page   <= '0;
      res_type   <= 1'b0;
      i_q        <= '0;
      pos_found  <= 1'b0;
    end
    if (cmd.load_b) begin
      if (raw > PW1'(REGION_PAGES)) begin
        cnt_q      <= NCW'(REGION_PAGES);
        res_status <= rbpa_pkg::ST_CLAMPED;
      end else begin
        cnt_q <= raw[NCW-1:0];
      end
    end
    if (cmd.scan) begin
      if (scan_end) begin
        unique case (func_q)
          rbpa_pkg::FN_ALLOC: res_status <= rbpa_pkg::ST_NOMEM;
          rbpa_pkg::FN_FREE:  res_status <= rbpa_pkg::ST_BADFREE;
          rbpa_pkg::FN_NEXT:  res_status <= rbpa_pkg::ST_NONE;
          default:            res_status <= res_status;
        endcase
      end else if (hit) begin
        unique case (func_q)
          rbpa_pkg::FN_LOAD: res_status <= rbpa_pkg::ST_OVERLAP;
          rbpa_pkg::FN_ALLOC: begin
            ram_addr_q <= slot_base;
            ofs_q      <= '0;
          end
          rbpa_pkg::FN_FREE: begin
            ram_addr_q <= slot_base + AW'(foff >> 6);
            bit_q      <= foff[5:0];
          end
          default: begin
            res_page <= (wq > ebytes) ? wq : ebytes;
            res_type <= !ra[idx];
          end
        endcase
      end else begin
        i_q <= i_q + CW'(1);
        // first region with a higher base marks the insert point
        if (!pos_found && eb > base_q) begin
          pos_q     <= i_q;
          pos_found <= 1'b1;
        end
      end
    end
    if (cmd.alloc_chk) begin
      if (a_found) begin
        res_page <= {eb + PW'(ofs_q) + PW'(first), {PAGE_SHIFT{1'b0}}};
      end else if (!a_last) begin
        ram_addr_q <= ram_addr_q + AW'(1);
        ofs_q      <= ofs_q + NCW'(64);
      end else begin
        i_q <= i_q + CW'(1);
      end
    end
    if (cmd.insert) begin
      for (int k = 0; k < MAX_REGIONS; k++) begin
        if (CW'(k) > ins_pos) begin
          rb[k] <= rb[(k > 0) ? k - 1 : 0];
          rc[k] <= rc[(k > 0) ? k - 1 : 0];
          ra[k] <= ra[(k > 0) ? k - 1 : 0];
          rs[k] <= rs[(k > 0) ? k - 1 : 0];
        end else if (CW'(k) == ins_pos) begin
          rb[k] <= base_q;
          rc[k] <= cnt_q;
          ra[k] <= (type_q == rbpa_pkg::ET_AVAIL);
          rs[k] <= region_count[IW-1:0];
        end
      end
    end
    if (cmd.finish && sts.out_free) begin
      status       <= res_status;
      page_address <= res_page;
      page_type    <= res_type;
    end
  end

  always_comb begin
    sts             = '0;
    sts.func        = func_q;
    sts.early       = early;
    sts.clear_last  = (clr_q == AW'(DEPTH - 1));
    sts.scan_end    = scan_end;
    sts.hit         = hit;
    sts.alloc_found = a_found;
    sts.alloc_last  = a_last;
    sts.out_free    = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    region_count <= CW'(MAX_REGIONS))
    else $error("region count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.insert |=> $stable(region_count))
    else $error("region count moved without an insert");

endmodule

// ----- rtl/region_bitmap_page_allocator.sv -----
// Top level of the region bitmap page allocator.
//
//  channel  direction  handshake          payload
//  in       to block   in_valid/in_ready  func, address, length, entry_type
//  out      from block out_valid/out_ready status, page_address, page_type
//  cfg      to block   APB psel/penable   paddr, pwdata, prdata (64 bit)
//
// After reset a clearing pass writes every bitmap word, MAX_REGIONS *
// ceil(REGION_PAGES/64) words (256 at defaults); no word is taken until done.
// One word at a time: load preps, sizes, scans, inserts; free scans, reads and
// writes a bitmap word; next-page scans; alloc reads, checks words (one read port).
// A finished result waits in the output register; a new word is taken meanwhile.
module region_bitmap_page_allocator #(
  parameter int MAX_REGIONS  = 4,
  parameter int REGION_PAGES = 4096,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [63:0]                  address,
  input  logic [63:0]                  length,
  input  logic [3:0]                   entry_type,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   status,
  output logic [63:0]                  page_address,
  output logic                         page_type,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  rbpa_pkg::cmd_t cmd;
  rbpa_pkg::sts_t sts;

  assign pready = 1'b1;

  rbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbpa_datapath #(
    .MAX_REGIONS  (MAX_REGIONS),
    .REGION_PAGES (REGION_PAGES),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .address      (address),
    .length       (length),
    .entry_type   (entry_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .page_address (page_address),
    .page_type    (page_type),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

endmodule
